// ===== sv/mahd_pkg.sv =====
// ----------------------------------------------------------------------------
// mahd_pkg
// Shared types, codes and constant tables for the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_SYNC   = 3'd1;
    localparam logic [2:0] ERR_VERSION   = 3'd2;
    localparam logic [2:0] ERR_LAYER     = 3'd3;
    localparam logic [2:0] ERR_BITRATE   = 3'd4;
    localparam logic [2:0] ERR_FREE_FMT  = 3'd5;
    localparam logic [2:0] ERR_RATE      = 3'd6;

    // raw version codes
    localparam logic [1:0] VER_MPEG25    = 2'd0;
    localparam logic [1:0] VER_RESERVED  = 2'd1;
    localparam logic [1:0] VER_MPEG2     = 2'd2;
    localparam logic [1:0] VER_MPEG1     = 2'd3;

    localparam int NUM_W   = 27;  // scaled numerator, max 92,160,000
    localparam int RECIP_W = 13;
    localparam int RECIP_S = 27;  // 2^RECIP_S exceeds every numerator
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QUOT_W  = 13;

    localparam logic [8:0] BR_TABLE [0:4][0:15] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    typedef struct packed {
        logic [2:0]  err;
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic [8:0]  br;
        logic [15:0] sr;
        logic        pad;
        logic [1:0]  chan;
        logic [15:0] bps;
        logic [1:0]  rate_sel;   // MPEG1 rate row: 44100, 48000, 32000
        logic        layer_one;
    } hdr_info_t;

    function automatic logic [8:0] bitrate_lookup(input logic [2:0] row,
                                                  input logic [3:0] idx);
        logic [8:0] val;
        begin
            val = 9'd0;
            if (row <= 3'd4)
            begin
                val = BR_TABLE[row][idx];
            end
            return val;
        end
    endfunction

    // MPEG1 sampling rate; MPEG2 and 2.5 are this shifted right by 1 and 2
    function automatic logic [15:0] rate_base(input logic [1:0] sel);
        logic [15:0] val;
        begin
            case (sel)
                2'd0:    val = 16'd44100;
                2'd1:    val = 16'd48000;
                2'd2:    val = 16'd32000;
                default: val = 16'd0;
            endcase
            return val;
        end
    endfunction

    // floor(2^RECIP_S / rate_base)
    function automatic logic [RECIP_W-1:0] rate_recip(input logic [1:0] sel);
        logic [RECIP_W-1:0] val;
        begin
            case (sel)
                2'd0:    val = 13'd3043;
                2'd1:    val = 13'd2796;
                2'd2:    val = 13'd4194;
                default: val = 13'd0;
            endcase
            return val;
        end
    endfunction

    // slot factor * 1000 * (MPEG1 rate / actual rate)
    function automatic logic [19:0] scale_const(input logic [1:0] layer,
                                                input logic [1:0] ver);
        logic [19:0] base;
        logic [19:0] val;
        begin
            if (layer == 2'd1)
            begin
                base = 20'd12000;
            end
            else if (layer == 2'd3 && ver != VER_MPEG1)
            begin
                base = 20'd72000;
            end
            else
            begin
                base = 20'd144000;
            end
            case (ver)
                VER_MPEG1: val = base;
                VER_MPEG2: val = base << 1;
                default:   val = base << 2;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== sv/mahd_decode.sv =====
// ----------------------------------------------------------------------------
// mahd_decode
// Stage 1: sync and field checks, table lookups, scale constant selection.
// ----------------------------------------------------------------------------
module mahd_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         header_word,
    output logic                out_valid,
    input  logic                out_ready,
    output mahd_pkg::hdr_info_t out_info,
    output logic [19:0]         out_scale
);

    logic                valid_reg;
    mahd_pkg::hdr_info_t info_reg;
    mahd_pkg::hdr_info_t info_next;
    logic [19:0]         scale_reg;
    logic [19:0]         scale_next;

    logic [1:0] ver;
    logic [1:0] lbits;
    logic [3:0] bidx;
    logic [1:0] sidx;
    logic [2:0] err;
    logic [1:0] layer;
    logic [2:0] row;
    logic [8:0] br;
    logic [15:0] bps_full;
    logic [1:0] sr_shift;

    assign ver   = header_word[20:19];
    assign lbits = header_word[18:17];
    assign bidx  = header_word[15:12];
    assign sidx  = header_word[11:10];
    assign layer = 2'(3'd4 - {1'b0, lbits});

    always_comb
    begin
        if (header_word[31:21] != 11'h7FF)
        begin
            err = mahd_pkg::ERR_NO_SYNC;
        end
        else if (ver == mahd_pkg::VER_RESERVED)
        begin
            err = mahd_pkg::ERR_VERSION;
        end
        else if (lbits == 2'd0)
        begin
            err = mahd_pkg::ERR_LAYER;
        end
        else if (bidx == 4'd15)
        begin
            err = mahd_pkg::ERR_BITRATE;
        end
        else if (bidx == 4'd0)
        begin
            err = mahd_pkg::ERR_FREE_FMT;
        end
        else if (sidx == 2'd3)
        begin
            err = mahd_pkg::ERR_RATE;
        end
        else
        begin
            err = mahd_pkg::ERR_NONE;
        end
    end

    // MPEG2/2.5: layer I uses row 3, layers II and III the low-rate row 4
    always_comb
    begin
        if (ver == mahd_pkg::VER_MPEG1)
        begin
            row = 3'({1'b0, layer} - 3'd1);
        end
        else
        begin
            row = (layer == 2'd1) ? 3'd3 : 3'd4;
        end
    end

    assign br       = mahd_pkg::bitrate_lookup(row, bidx);
    assign bps_full = 16'(br * 7'd125);

    // MPEG2 halves the MPEG1 rate, MPEG2.5 quarters it
    assign sr_shift = (ver == mahd_pkg::VER_MPEG1) ? 2'd0 :
                      (ver == mahd_pkg::VER_MPEG2) ? 2'd1 : 2'd2;

    always_comb
    begin
        info_next  = '0;
        scale_next = '0;
        info_next.err = err;
        if (err == mahd_pkg::ERR_NONE)
        begin
            info_next.ver       = ver;
            info_next.layer     = layer;
            info_next.br        = br;
            info_next.sr        = mahd_pkg::rate_base(sidx) >> sr_shift;
            info_next.pad       = header_word[9];
            info_next.chan      = (header_word[7:6] == 2'd3) ? 2'd1 : 2'd2;
            info_next.bps       = bps_full;
            info_next.rate_sel  = sidx;
            info_next.layer_one = (layer == 2'd1);
            scale_next          = mahd_pkg::scale_const(layer, ver);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_info  = info_reg;
    assign out_scale = scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            info_reg  <= info_next;
            scale_reg <= scale_next;
        end
    end

endmodule

// ===== sv/mahd_mul.sv =====
// ----------------------------------------------------------------------------
// mahd_mul
// Stages 2 and 3: form the scaled numerator, then multiply it by the
// reciprocal of the rate base.
// ----------------------------------------------------------------------------
module mahd_mul
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mahd_pkg::hdr_info_t            in_info,
    input  logic [19:0]                    in_scale,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mahd_pkg::hdr_info_t            out_info,
    output logic [mahd_pkg::NUM_W-1:0]     out_num,
    output logic [mahd_pkg::PROD_W-1:0]    out_prod
);

    logic                               num_valid_reg;
    mahd_pkg::hdr_info_t                num_info_reg;
    logic [mahd_pkg::NUM_W-1:0]         num_reg;
    logic [mahd_pkg::NUM_W-1:0]         num_next;
    logic [28:0]                        num_full;

    logic                               prod_valid_reg;
    mahd_pkg::hdr_info_t                prod_info_reg;
    logic [mahd_pkg::NUM_W-1:0]         prod_num_reg;
    logic [mahd_pkg::PROD_W-1:0]        prod_reg;
    logic [mahd_pkg::PROD_W-1:0]        prod_next;
    logic                               prod_ready;

    assign num_full = in_info.br * in_scale;
    assign num_next = num_full[mahd_pkg::NUM_W-1:0];
    assign prod_next = num_reg * mahd_pkg::rate_recip(num_info_reg.rate_sel);

    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_ready   = !num_valid_reg || prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                num_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                prod_valid_reg <= num_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            num_info_reg <= in_info;
            num_reg      <= num_next;
        end
        if (prod_ready && num_valid_reg)
        begin
            prod_info_reg <= num_info_reg;
            prod_num_reg  <= num_reg;
            prod_reg      <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_info  = prod_info_reg;
    assign out_num   = prod_num_reg;
    assign out_prod  = prod_reg;

endmodule

// ===== sv/mahd_fix.sv =====
// ----------------------------------------------------------------------------
// mahd_fix
// Stages 4 and 5: back-multiply the quotient estimate, correct it by one
// where the remainder still reaches the divisor, and form the frame length.
// ----------------------------------------------------------------------------
module mahd_fix
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mahd_pkg::hdr_info_t            in_info,
    input  logic [mahd_pkg::NUM_W-1:0]     in_num,
    input  logic [mahd_pkg::PROD_W-1:0]    in_prod,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mahd_pkg::hdr_info_t            out_info,
    output logic [12:0]                    out_frame_bytes
);

    logic                               chk_valid_reg;
    mahd_pkg::hdr_info_t                chk_info_reg;
    logic [mahd_pkg::NUM_W-1:0]         chk_num_reg;
    logic [mahd_pkg::QUOT_W-1:0]        quot_reg;
    logic [mahd_pkg::QUOT_W-1:0]        quot_next;
    logic [mahd_pkg::NUM_W-1:0]         back_reg;
    logic [mahd_pkg::NUM_W-1:0]         back_next;
    logic [28:0]                        back_full;
    logic                               chk_ready;

    logic                               res_valid_reg;
    mahd_pkg::hdr_info_t                res_info_reg;
    logic [12:0]                        fb_reg;
    logic [12:0]                        fb_next;
    logic [mahd_pkg::NUM_W-1:0]         rem;
    logic [15:0]                        divisor;
    logic [mahd_pkg::QUOT_W:0]          quot_fixed;
    logic [mahd_pkg::QUOT_W+1:0]        slots;

    assign quot_next = in_prod[mahd_pkg::PROD_W-1:mahd_pkg::RECIP_S];
    assign back_full = quot_next * mahd_pkg::rate_base(in_info.rate_sel);
    assign back_next = back_full[mahd_pkg::NUM_W-1:0];

    // estimate is exact or one short
    assign divisor    = mahd_pkg::rate_base(chk_info_reg.rate_sel);
    assign rem        = chk_num_reg - back_reg;
    assign quot_fixed = {1'b0, quot_reg} + {{mahd_pkg::QUOT_W{1'b0}},
                        (rem >= {{(mahd_pkg::NUM_W-16){1'b0}}, divisor})};
    assign slots      = {1'b0, quot_fixed}
                        + {{(mahd_pkg::QUOT_W+1){1'b0}}, chk_info_reg.pad};
    assign fb_next    = chk_info_reg.layer_one ? 13'({slots, 2'b00}) : slots[12:0];

    assign chk_ready = !res_valid_reg || out_ready;
    assign in_ready  = !chk_valid_reg || chk_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                chk_valid_reg <= in_valid;
            end
            if (chk_ready)
            begin
                res_valid_reg <= chk_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            chk_info_reg <= in_info;
            chk_num_reg  <= in_num;
            quot_reg     <= quot_next;
            back_reg     <= back_next;
        end
        if (chk_ready && chk_valid_reg)
        begin
            res_info_reg <= chk_info_reg;
            fb_reg       <= fb_next;
        end
    end

    assign out_valid       = res_valid_reg;
    assign out_info        = res_info_reg;
    assign out_frame_bytes = fb_reg;

endmodule

// ===== sv/mpeg_audio_header_decoder.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// Decodes 32-bit MPEG audio frame headers into rates and frame length.
// ----------------------------------------------------------------------------
// One header enters per cycle while the master side is ready; each result
// passes five register stages (decode, numerator, reciprocal multiply,
// back-multiply, correct). The frame length divide is a multiply by a
// constant reciprocal of the MPEG1 rate, followed by a one-step correction.
// Backpressure on the master side stalls only the stages that are full;
// empty stages keep accepting. Any error code other than zero zeroes all
// other result fields.
module mpeg_audio_header_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // header_word
    output logic        m_tvalid,
    input  logic        m_tready,
    // error_code, version_code, layer_number, bitrate_kbps, sample_rate_hz,
    // padding_bit, channel_count, frame_bytes, bytes_per_second
    output logic [63:0] m_tdata
);

    logic                              dec_valid;
    logic                              dec_ready;
    mahd_pkg::hdr_info_t               dec_info;
    logic [19:0]                       dec_scale;

    logic                              mul_valid;
    logic                              mul_ready;
    mahd_pkg::hdr_info_t               mul_info;
    logic [mahd_pkg::NUM_W-1:0]        mul_num;
    logic [mahd_pkg::PROD_W-1:0]       mul_prod;

    mahd_pkg::hdr_info_t               res_info;
    logic [12:0]                       res_fb;

    mahd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .header_word (s_tdata),
        .out_valid   (dec_valid),
        .out_ready   (dec_ready),
        .out_info    (dec_info),
        .out_scale   (dec_scale)
    );

    mahd_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_info   (dec_info),
        .in_scale  (dec_scale),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_info  (mul_info),
        .out_num   (mul_num),
        .out_prod  (mul_prod)
    );

    mahd_fix u_fix
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (mul_valid),
        .in_ready        (mul_ready),
        .in_info         (mul_info),
        .in_num          (mul_num),
        .in_prod         (mul_prod),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_info        (res_info),
        .out_frame_bytes (res_fb)
    );

    assign m_tdata = {res_info.bps, res_fb, res_info.chan, res_info.pad,
                      res_info.sr, res_info.br, res_info.layer, res_info.ver,
                      res_info.err};

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != mahd_pkg::ERR_NONE |-> m_tdata[63:3] == '0)
        else $error("error result carries nonzero fields");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == mahd_pkg::ERR_NONE
            |-> m_tdata[47:35] != '0 && m_tdata[63:48] != '0)
        else $error("valid header gave zero frame length or rate");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("pipeline stalled with downstream ready");
`endif

endmodule
